// ===== src/rebnf_pkg.sv =====
// ----------------------------------------------------------------------------
// rebnf_pkg
// Shared types, constants and helpers for the random-erase noise fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package rebnf_pkg;

  // Noise tile side, a power of two; the store holds one full tile.
  localparam int NOISE_SIDE  = 64;
  localparam int NOISE_SW    = $clog2(NOISE_SIDE);
  localparam int NOISE_DEPTH = NOISE_SIDE * NOISE_SIDE;
  localparam int NOISE_AW    = $clog2(NOISE_DEPTH);
  localparam int MAX_DIM     = 4096;
  localparam int CHANNELS    = 3;

  localparam int PIX_W   = 8;
  localparam int WORD_W  = 3 * PIX_W;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int IMG_W   = 10;
  localparam int ADDR_W  = 12;
  localparam int CFG_IW  = 3;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_LOAD  = 1'b1
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BOX_LEFT   = 3'd0,
    CFG_BOX_TOP    = 3'd1,
    CFG_BOX_RIGHT  = 3'd2,
    CFG_BOX_BOTTOM = 3'd3,
    CFG_ROI_X      = 3'd4,
    CFG_ROI_Y      = 3'd5,
    CFG_ROI_WIDTH  = 3'd6,
    CFG_ROI_HEIGHT = 3'd7
  } cfg_reg_t;

  // Clamped erase box, ready for compare against pixel coordinates.
  typedef struct packed {
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] bottom;
    logic             nonempty;
  } box_t;

  // lo if v < lo, else v if v < hi, else hi
  function automatic logic [DIM_W-1:0] clamp_range(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lo,
                                                   input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v < hi) begin
      r = v;
    end else begin
      r = hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/rebnf_ram.sv =====
// ----------------------------------------------------------------------------
// rebnf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rebnf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rebnf_box.sv =====
// ----------------------------------------------------------------------------
// rebnf_box
// Configuration registers and registered clamp of the erase box.
// ----------------------------------------------------------------------------
`default_nettype none

module rebnf_box (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rebnf_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [rebnf_pkg::DIM_W-1:0]   cfg_data,
  output rebnf_pkg::box_t                    box
);

  logic [rebnf_pkg::COORD_W-1:0] box_left_r, box_top_r, box_right_r, box_bottom_r;
  logic [rebnf_pkg::COORD_W-1:0] roi_x_r, roi_y_r;
  logic [rebnf_pkg::DIM_W-1:0]   roi_width_r, roi_height_r;
  logic [rebnf_pkg::DIM_W-1:0]   left_c, top_c, right_c, bottom_c;
  rebnf_pkg::box_t               box_r, box_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_right_r  <= '0;
      box_bottom_r <= '0;
      roi_x_r      <= '0;
      roi_y_r      <= '0;
      roi_width_r  <= rebnf_pkg::DIM_W'(rebnf_pkg::MAX_DIM);
      roi_height_r <= rebnf_pkg::DIM_W'(rebnf_pkg::MAX_DIM);
    end else if (cfg_we) begin
      unique case (rebnf_pkg::cfg_reg_t'(cfg_index))
        rebnf_pkg::CFG_BOX_LEFT:   box_left_r   <= cfg_data[rebnf_pkg::COORD_W-1:0];
        rebnf_pkg::CFG_BOX_TOP:    box_top_r    <= cfg_data[rebnf_pkg::COORD_W-1:0];
        rebnf_pkg::CFG_BOX_RIGHT:  box_right_r  <= cfg_data[rebnf_pkg::COORD_W-1:0];
        rebnf_pkg::CFG_BOX_BOTTOM: box_bottom_r <= cfg_data[rebnf_pkg::COORD_W-1:0];
        rebnf_pkg::CFG_ROI_X:      roi_x_r      <= cfg_data[rebnf_pkg::COORD_W-1:0];
        rebnf_pkg::CFG_ROI_Y:      roi_y_r      <= cfg_data[rebnf_pkg::COORD_W-1:0];
        rebnf_pkg::CFG_ROI_WIDTH:  roi_width_r  <= cfg_data;
        rebnf_pkg::CFG_ROI_HEIGHT: roi_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // right and bottom clamp against the already clamped left and top
  always_comb begin
    left_c   = rebnf_pkg::clamp_range({1'b0, box_left_r}, {1'b0, roi_x_r}, roi_width_r);
    top_c    = rebnf_pkg::clamp_range({1'b0, box_top_r}, {1'b0, roi_y_r}, roi_height_r);
    right_c  = rebnf_pkg::clamp_range({1'b0, box_right_r}, left_c, roi_width_r);
    bottom_c = rebnf_pkg::clamp_range({1'b0, box_bottom_r}, top_c, roi_height_r);
    box_nxt.left     = left_c;
    box_nxt.right    = right_c;
    box_nxt.top      = top_c;
    box_nxt.bottom   = bottom_c;
    box_nxt.nonempty = (left_c <= right_c) && (top_c <= bottom_c);
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

  assign box = box_r;

endmodule

`default_nettype wire

// ===== src/random_erase_box_noise_fill.sv =====
// ----------------------------------------------------------------------------
// random_erase_box_noise_fill
// Replaces pixels inside a clamped erase box with tiled noise from a store.
// ----------------------------------------------------------------------------
// Result path: noise read in stage 1, then the output register, then result valid.
// Throughput: 1 request per cycle unless the output stalls; one noise store read or
// write per request. The single-port-pair noise RAM sets this figure.
// Reset (synchronous, rst_n low): pipeline empty, box registers 0, ROI size 4096.
// Noise store contents are not cleared; entries are undefined until loaded.
// A config write reaches the box test via the config registers and registered clamp.
`default_nettype none

module random_erase_box_noise_fill (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rebnf_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [rebnf_pkg::DIM_W-1:0]    cfg_data,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_operation,
  input  wire logic [rebnf_pkg::COORD_W-1:0]  in_row,
  input  wire logic [rebnf_pkg::COORD_W-1:0]  in_col,
  input  wire logic [rebnf_pkg::IMG_W-1:0]    in_image_index,
  input  wire logic [rebnf_pkg::ADDR_W-1:0]   in_noise_addr,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    in_red,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    in_green,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    in_blue,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [rebnf_pkg::PIX_W-1:0]    out_red,
  output logic      [rebnf_pkg::PIX_W-1:0]    out_green,
  output logic      [rebnf_pkg::PIX_W-1:0]    out_blue,
  output logic                                out_erased
);

  // ---- handshake ----------------------------------------------------------
  logic acc;        // request accepted this edge
  logic s1_adv;     // stage 1 moves into the output register
  logic out_free;   // output register empty or draining

  // ---- stage 1: noise read in flight -------------------------------------
  logic                            s1_valid_r;
  rebnf_pkg::op_t                  s1_op_r;
  logic [rebnf_pkg::COORD_W-1:0]   s1_row_r, s1_col_r;
  logic [rebnf_pkg::WORD_W-1:0]    s1_src_r;

  // ---- output register ----------------------------------------------------
  logic                            out_valid_r;
  logic [rebnf_pkg::PIX_W-1:0]     out_red_r, out_green_r, out_blue_r;
  logic                            out_erased_r;
  logic [rebnf_pkg::PIX_W-1:0]     out_red_nxt, out_green_nxt, out_blue_nxt;
  logic                            out_erased_nxt;

  // ---- noise store ports --------------------------------------------------
  logic                            ram_we, ram_re;
  logic [rebnf_pkg::NOISE_AW-1:0]  ram_waddr, ram_raddr;
  logic [rebnf_pkg::WORD_W-1:0]    ram_wdata, ram_rdata;
  logic [rebnf_pkg::IMG_W:0]       row_sum;
  logic [rebnf_pkg::NOISE_SW-1:0]  noise_row, noise_col;

  rebnf_pkg::box_t                 box;
  logic                            hit;
  logic [rebnf_pkg::WORD_W-1:0]    pix;

  // Config is always taken; the user must write it only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  rebnf_box u_box (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box       (box)
  );

  // Stage 1 only blocks when it holds a request and the output is stuck.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign acc      = in_valid && !in_stall;
  assign s1_adv   = s1_valid_r && out_free;

  // Noise index: tile row from (row + image index) mod side, column mod side.
  // Side is a power of two, so both are low-bit selects.
  assign row_sum   = {1'b0, in_row[rebnf_pkg::IMG_W-1:0]}
                   + {1'b0, in_image_index};
  assign noise_row = row_sum[rebnf_pkg::NOISE_SW-1:0];
  assign noise_col = in_col[rebnf_pkg::NOISE_SW-1:0];

  // A load writes at its accept edge; a pixel reads at its accept edge.
  // Only one request per edge, so a read always sees every earlier load:
  // no forwarding path is needed.
  // Read enable follows accept only, so rdata holds while stage 1 stalls.
  assign ram_we    = acc && (rebnf_pkg::op_t'(in_operation) == rebnf_pkg::OP_LOAD)
                   && ({1'b0, in_noise_addr} < (rebnf_pkg::ADDR_W+1)'(rebnf_pkg::NOISE_DEPTH));
  assign ram_waddr = in_noise_addr[rebnf_pkg::NOISE_AW-1:0];
  assign ram_wdata = {in_blue, in_green, in_red};
  assign ram_re    = acc && (rebnf_pkg::op_t'(in_operation) == rebnf_pkg::OP_PIXEL);
  assign ram_raddr = {noise_row, noise_col};

  rebnf_ram #(
    .WIDTH (rebnf_pkg::WORD_W),
    .DEPTH (rebnf_pkg::NOISE_DEPTH)
  ) u_noise (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op_r  <= rebnf_pkg::op_t'(in_operation);
      s1_row_r <= in_row;
      s1_col_r <= in_col;
      s1_src_r <= {in_blue, in_green, in_red};
    end
  end

  // Box test; an empty box never hits.
  assign hit = (s1_op_r == rebnf_pkg::OP_PIXEL) && box.nonempty
            && ({1'b0, s1_col_r} >= box.left) && ({1'b0, s1_col_r} <= box.right)
            && ({1'b0, s1_row_r} >= box.top)  && ({1'b0, s1_row_r} <= box.bottom);

  always_comb begin
    if (s1_op_r == rebnf_pkg::OP_LOAD) begin
      pix = '0;                 // load result is all zero
    end else if (hit) begin
      pix = ram_rdata;
    end else begin
      pix = s1_src_r;
    end
    // channels past the configured count read as zero
    out_red_nxt    = (rebnf_pkg::CHANNELS > 0) ? pix[rebnf_pkg::PIX_W-1:0] : '0;
    out_green_nxt  = (rebnf_pkg::CHANNELS > 1) ?
                     pix[2*rebnf_pkg::PIX_W-1:rebnf_pkg::PIX_W] : '0;
    out_blue_nxt   = (rebnf_pkg::CHANNELS > 2) ?
                     pix[3*rebnf_pkg::PIX_W-1:2*rebnf_pkg::PIX_W] : '0;
    out_erased_nxt = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_red_r    <= out_red_nxt;
      out_green_r  <= out_green_nxt;
      out_blue_r   <= out_blue_nxt;
      out_erased_r <= out_erased_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_red    = out_red_r;
  assign out_green  = out_green_r;
  assign out_blue   = out_blue_r;
  assign out_erased = out_erased_r;

  // ---- assertions ---------------------------------------------------------
  // Backpressure only when both stages are full and the sink stalls.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // A held stage 1 must keep its noise read data.
  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(ram_rdata)))
    else $error("noise read data lost while stage 1 stalled");

  // A request leaving stage 1 lands in the output register.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("stage 1 request dropped");

  // No store access without an accepted request.
  a_ram_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we || ram_re) |-> (in_valid && !in_stall))
    else $error("noise store accessed without a request");

endmodule

`default_nettype wire

// ===== tb/erase_fill_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erase_fill_checker
// Watches the config, request and result channels of the erase block, keeps
// its own copy of the box registers and the noise tile, predicts each result
// and compares it field by field in arrival order.
// ----------------------------------------------------------------------------

module erase_fill_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [rebnf_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [rebnf_pkg::DIM_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic                           in_operation,
  input  wire logic [rebnf_pkg::COORD_W-1:0]  in_row,
  input  wire logic [rebnf_pkg::COORD_W-1:0]  in_col,
  input  wire logic [rebnf_pkg::IMG_W-1:0]    in_image_index,
  input  wire logic [rebnf_pkg::ADDR_W-1:0]   in_noise_addr,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    in_red,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    in_green,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    in_blue,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    out_red,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    out_green,
  input  wire logic [rebnf_pkg::PIX_W-1:0]    out_blue,
  input  wire logic                           out_erased,
  output int                                  mismatches,
  output int                                  in_flight
);
  import rebnf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             erased;
  } pixel_out_t;

  logic [COORD_W-1:0] req_left, req_top, req_right, req_bottom;
  logic [COORD_W-1:0] roi_x0, roi_y0;
  logic [DIM_W-1:0]   roi_w, roi_h;
  logic [WORD_W-1:0]  noise_copy [NOISE_DEPTH];
  pixel_out_t         pending_pixels [$];
  int                 fails = 0;

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  function automatic int pin(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v < hi) return v;
    return hi;
  endfunction

  // Clamp the requested box into the ROI, then pick noise or pass-through.
  function automatic pixel_out_t erase_or_pass(input logic [COORD_W-1:0] row_in,
                                               input logic [COORD_W-1:0] col_in,
                                               input logic [IMG_W-1:0]   img_in,
                                               input logic [PIX_W-1:0]   r,
                                               input logic [PIX_W-1:0]   g,
                                               input logic [PIX_W-1:0]   b);
    int               row, col, img, left, top, right, bottom, slot;
    logic [WORD_W-1:0] word;
    pixel_out_t       res;
    row    = int'(row_in);
    col    = int'(col_in);
    img    = int'(img_in);
    left   = pin(int'(req_left),   int'(roi_x0), int'(roi_w));
    top    = pin(int'(req_top),    int'(roi_y0), int'(roi_h));
    right  = pin(int'(req_right),  left,         int'(roi_w));
    bottom = pin(int'(req_bottom), top,          int'(roi_h));
    if (left <= right && top <= bottom &&
        col >= left && col <= right && row >= top && row <= bottom) begin
      slot       = ((row + img) % NOISE_SIDE) * NOISE_SIDE + (col % NOISE_SIDE);
      word       = noise_copy[slot];
      res.red    = word[7:0];
      res.green  = word[15:8];
      res.blue   = word[23:16];
      res.erased = 1'b1;
    end else begin
      res.red    = r;
      res.green  = g;
      res.blue   = b;
      res.erased = 1'b0;
    end
    if (CHANNELS < 3) res.blue = '0;
    if (CHANNELS < 2) res.green = '0;
    return res;
  endfunction

  task automatic report(input string field, input int want, input int got);
    fails++;
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin : watch
    pixel_out_t want;
    if (!rst_n) begin
      req_left   = '0;
      req_top    = '0;
      req_right  = '0;
      req_bottom = '0;
      roi_x0     = '0;
      roi_y0     = '0;
      roi_w      = DIM_W'(MAX_DIM);
      roi_h      = DIM_W'(MAX_DIM);
      pending_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BOX_LEFT:   req_left   = cfg_data[COORD_W-1:0];
          CFG_BOX_TOP:    req_top    = cfg_data[COORD_W-1:0];
          CFG_BOX_RIGHT:  req_right  = cfg_data[COORD_W-1:0];
          CFG_BOX_BOTTOM: req_bottom = cfg_data[COORD_W-1:0];
          CFG_ROI_X:      roi_x0     = cfg_data[COORD_W-1:0];
          CFG_ROI_Y:      roi_y0     = cfg_data[COORD_W-1:0];
          CFG_ROI_WIDTH:  roi_w      = cfg_data;
          CFG_ROI_HEIGHT: roi_h      = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_operation == OP_LOAD) begin
          // store depth equals the address range, so every load lands
          noise_copy[in_noise_addr] = {in_blue, in_green, in_red};
          pending_pixels.push_back('0);
        end else begin
          pending_pixels.push_back(erase_or_pass(in_row, in_col, in_image_index,
                                                 in_red, in_green, in_blue));
        end
      end

      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          fails++;
          $error("result with no request outstanding: rgb %0d %0d %0d erased %0d",
                 out_red, out_green, out_blue, out_erased);
        end else begin
          want = pending_pixels.pop_front();
          if (out_red !== want.red)
            report("out_red", int'(want.red), int'(out_red));
          if (out_green !== want.green)
            report("out_green", int'(want.green), int'(out_green));
          if (out_blue !== want.blue)
            report("out_blue", int'(want.blue), int'(out_blue));
          if (out_erased !== want.erased)
            report("out_erased", int'(want.erased), int'(out_erased));
        end
      end
    end
    mismatches <= fails;
    in_flight  <= pending_pixels.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the random-erase noise fill block: directed box edge, empty
// box and clamp cases, then randomized phases over several box/ROI settings
// with sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb;
  import rebnf_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int HOLD_CYCLES = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = 1'b0;
  logic [COORD_W-1:0]  in_row = '0;
  logic [COORD_W-1:0]  in_col = '0;
  logic [IMG_W-1:0]    in_image_index = '0;
  logic [ADDR_W-1:0]   in_noise_addr = '0;
  logic [PIX_W-1:0]    in_red = '0;
  logic [PIX_W-1:0]    in_green = '0;
  logic [PIX_W-1:0]    in_blue = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PIX_W-1:0]    out_red;
  logic [PIX_W-1:0]    out_green;
  logic [PIX_W-1:0]    out_blue;
  logic                out_erased;
  int                  mismatches;
  int                  in_flight;

  // idle percentages: gap_pct is only used by the request driver, stall_pct
  // is handed to the stall process by nonblocking write
  int                  gap_pct = 0;
  int                  stall_pct = 0;
  logic                hold_request = 1'b0;
  logic                hold_done = 1'b0;
  int                  hold_left = 0;

  // requests taken so far, loads included; each phase sends at least PHASE_ITEMS
  int                  sent = 0;
  int                  phase_end = 0;

  // tracks which noise entries have been loaded; a pixel is never sent whose
  // noise slot is still unloaded
  bit                  noise_loaded [NOISE_DEPTH];

  // requested box of the current setting, used to aim pixels near its edges
  int                  aim_left, aim_top, aim_right, aim_bottom;

  random_erase_box_noise_fill uut (.*);
  erase_fill_checker          chk (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // pipeline backs up and the block has to stall its input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Safety net against a hung pipeline.
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Present one request, optionally after random gap cycles, and hold it
  // until the block takes it. Returns at the accepting edge.
  task automatic offer(input op_t op, input logic [COORD_W-1:0] row,
                       input logic [COORD_W-1:0] col, input logic [IMG_W-1:0] img,
                       input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] r,
                       input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_row         <= row;
    in_col         <= col;
    in_image_index <= img;
    in_noise_addr  <= addr;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Load request; row, col and image index are don't-care and get noise.
  task automatic load_word(input int addr, input logic [PIX_W-1:0] r,
                           input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    offer(OP_LOAD, COORD_W'($urandom_range(4095, 0)), COORD_W'($urandom_range(4095, 0)),
          IMG_W'($urandom_range(1023, 0)), ADDR_W'(addr), r, g, b);
    noise_loaded[addr] = 1'b1;
  endtask

  task automatic load_random(input int addr);
    load_word(addr, PIX_W'($urandom_range(255, 0)), PIX_W'($urandom_range(255, 0)),
              PIX_W'($urandom_range(255, 0)));
  endtask

  // Pixel request; loads its noise slot first if that entry is still empty.
  task automatic send_pixel(input int row, input int col, input int img,
                            input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    int slot;
    slot = ((row + img) % NOISE_SIDE) * NOISE_SIDE + (col % NOISE_SIDE);
    if (!noise_loaded[slot]) load_random(slot);
    offer(OP_PIXEL, COORD_W'(row), COORD_W'(col), IMG_W'(img),
          ADDR_W'($urandom_range(4095, 0)), r, g, b);
  endtask

  // Stop offering and wait until every result is back, then idle to let the
  // two-stage pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DIM_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Full register update, only with the pipeline empty.
  task automatic apply_settings(input int bl, input int bt, input int br, input int bb,
                                input int rx, input int ry, input int rw, input int rh);
    drain();
    write_reg(CFG_BOX_LEFT, bl);
    write_reg(CFG_BOX_TOP, bt);
    write_reg(CFG_BOX_RIGHT, br);
    write_reg(CFG_BOX_BOTTOM, bb);
    write_reg(CFG_ROI_X, rx);
    write_reg(CFG_ROI_Y, ry);
    write_reg(CFG_ROI_WIDTH, rw);
    write_reg(CFG_ROI_HEIGHT, rh);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
    aim_left   = bl;
    aim_top    = bt;
    aim_right  = br;
    aim_bottom = bb;
  endtask

  // Mostly narrow boxes so erasures are common; ROI offsets sometimes pull
  // the left/top edge in, ROI size sometimes cuts the box or empties it.
  task automatic random_settings();
    int bl, bt, br, bb, rx, ry, rw, rh;
    bl = $urandom_range(4095, 0);
    bt = $urandom_range(4095, 0);
    br = ($urandom_range(3, 0) == 0) ? $urandom_range(4095, 0) : bl + $urandom_range(40, 0);
    bb = ($urandom_range(3, 0) == 0) ? $urandom_range(4095, 0) : bt + $urandom_range(40, 0);
    if (br > 4095) br = 4095;
    if (bb > 4095) bb = 4095;
    rx = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(bl + 8 > 4095 ? 4095 : bl + 8, 0);
    ry = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(bt + 8 > 4095 ? 4095 : bt + 8, 0);
    rw = ($urandom_range(2, 0) == 0) ? $urandom_range(MAX_DIM, 0) : MAX_DIM;
    rh = ($urandom_range(2, 0) == 0) ? $urandom_range(MAX_DIM, 0) : MAX_DIM;
    apply_settings(bl, bt, br, bb, rx, ry, rw, rh);
  endtask

  // Coordinate within two of a requested span, clipped to the frame.
  function automatic int near_span(input int a, input int b);
    int lo, hi;
    lo = ((a < b) ? a : b) - 2;
    hi = ((a < b) ? b : a) + 2;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    return $urandom_range(hi, lo);
  endfunction

  task automatic random_pixel();
    int row, col;
    if ($urandom_range(9, 0) < 6) begin
      row = near_span(aim_top, aim_bottom);
      col = near_span(aim_left, aim_right);
    end else begin
      row = $urandom_range(4095, 0);
      col = $urandom_range(4095, 0);
    end
    send_pixel(row, col, $urandom_range(1023, 0), PIX_W'($urandom_range(255, 0)),
               PIX_W'($urandom_range(255, 0)), PIX_W'($urandom_range(255, 0)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset setting, box collapses to the single pixel (0,0)
    aim_left = 0; aim_top = 0; aim_right = 0; aim_bottom = 0;
    load_word(0, 8'h00, 8'h00, 8'h00);
    load_word(4095, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(0, 0, 0, 8'hFF, 8'hFF, 8'hFF);          // erased, zero noise
    send_pixel(0, 1, 0, 8'h00, 8'hFF, 8'h00);          // one column right
    send_pixel(1, 0, 0, 8'hFF, 8'h00, 8'hFF);          // one row down
    send_pixel(0, 0, 1023, 8'h5A, 8'hA5, 8'h3C);       // image index wraps noise row
    send_pixel(4095, 4095, 1023, 8'hFF, 8'hFF, 8'hFF); // far corner, passes

    // ---- directed: ordinary box, inclusive edges and just outside
    apply_settings(10, 5, 20, 9, 0, 0, MAX_DIM, MAX_DIM);
    send_pixel(5, 10, 0, 8'h11, 8'h22, 8'h33);
    send_pixel(9, 20, 0, 8'h44, 8'h55, 8'h66);
    send_pixel(4, 10, 0, 8'h77, 8'h88, 8'h99);
    send_pixel(10, 20, 0, 8'hAA, 8'hBB, 8'hCC);
    send_pixel(5, 9, 0, 8'hDD, 8'hEE, 8'hFF);
    send_pixel(5, 21, 0, 8'h01, 8'h02, 8'h03);
    send_pixel(7, 15, 1023, 8'h80, 8'h40, 8'h20);

    // ---- directed: empty box, ROI width below the clamped left edge
    apply_settings(100, 0, 400, 4095, 300, 0, 250, MAX_DIM);
    send_pixel(3, 250, 0, 8'h12, 8'h34, 8'h56);
    send_pixel(3, 275, 0, 8'h78, 8'h9A, 8'hBC);
    send_pixel(3, 300, 0, 8'hDE, 8'hF0, 8'h0F);

    // ---- directed: box pulled in by the ROI on every side
    apply_settings(5, 5, 4095, 4095, 50, 60, 100, 120);
    send_pixel(60, 49, 0, 8'h10, 8'h20, 8'h30);
    send_pixel(60, 50, 0, 8'h40, 8'h50, 8'h60);
    send_pixel(120, 100, 0, 8'h70, 8'h80, 8'h90);
    send_pixel(121, 100, 0, 8'hA0, 8'hB0, 8'hC0);
    send_pixel(59, 101, 0, 8'hD0, 8'hE0, 8'hF0);

    // ---- random phases
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_settings(0, 0, 4095, 4095, 0, 0, MAX_DIM, MAX_DIM); // erase everything
        5: apply_settings(0, 0, 3, 3, 0, 0, 0, 0);                   // zero-size ROI
        6: apply_settings(4095, 4095, 4095, 4095, 4095, 4095, MAX_DIM, MAX_DIM);
        default: random_settings();
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 52; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 52; end
        default: begin gap_pct = 9; stall_pct <= 9; end
      endcase
      // back-pressure phase: sender runs flat out while the receiver holds off
      if (phase == 4) hold_request <= 1'b1;
      // noise loads made on demand count toward the phase budget
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        if ($urandom_range(99, 0) < 10) load_random($urandom_range(4095, 0));
        else random_pixel();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
